@@ rtl/core/bchd_pkg.sv @@
// Shared types, widths and codes for the button click and hold detector.
// No dependencies; every other file of the block imports it.
package bchd_pkg;

    localparam int TICKS_PER_SECOND = 100;
    localparam int PRESCALE_W       = $clog2(TICKS_PER_SECOND + 1);
    localparam logic [PRESCALE_W-1:0] PRESCALE_LAST = PRESCALE_W'(TICKS_PER_SECOND - 1);

    localparam int FUNC_W     = 2;
    localparam int MODE_W     = 2;
    localparam int SECS_W     = 8;
    localparam int EVT_W      = 3;
    localparam int STATE_W    = 3;
    localparam int MASK_W     = 7;
    localparam int LED_W      = 2;
    localparam int TIME_W     = 8;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 8;
    localparam int NUM_EV     = 6;

    localparam int EVB_COVERED    = 0;
    localparam int EVB_FREE       = 1;
    localparam int EVB_CLICKED    = 2;
    localparam int EVB_DOUBLE     = 3;
    localparam int EVB_HOLD_START = 4;
    localparam int EVB_HOLD_END   = 5;
    localparam int EVB_FEEDBACK   = 6;

    localparam logic [MASK_W-1:0] RST_EVENT_MASK  = 7'd127;
    localparam logic [TIME_W-1:0] RST_HOLD_TIME   = 8'd100;
    localparam logic [TIME_W-1:0] RST_DCLICK_TIME = 8'd50;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_LEVEL  = 2'd0,
        FUNC_TICK   = 2'd1,
        FUNC_ENABLE = 2'd2,
        FUNC_STATUS = 2'd3
    } t_func;

    typedef enum logic [MODE_W-1:0] {
        MODE_DISABLE = 2'd0,
        MODE_ENABLE  = 2'd1,
        MODE_INVERT  = 2'd2
    } t_mode;

    typedef enum logic [STATE_W-1:0] {
        ST_RELEASED        = 3'd0,
        ST_PRESSED         = 3'd1,
        ST_HOLD            = 3'd2,
        ST_CLICKED         = 3'd3,
        ST_CLICKED_PRESSED = 3'd4
    } t_state;

    typedef enum logic [EVT_W-1:0] {
        EV_NONE       = 3'd0,
        EV_COVERED    = 3'd1,
        EV_FREE       = 3'd2,
        EV_CLICKED    = 3'd3,
        EV_DOUBLE     = 3'd4,
        EV_HOLD_START = 3'd5,
        EV_HOLD_END   = 3'd6
    } t_event;

    typedef enum logic [LED_W-1:0] {
        LED_NONE = 2'd0,
        LED_ON   = 2'd1,
        LED_OFF  = 2'd2
    } t_led;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_EVENT_MASK  = 2'd0,
        CFG_HOLD_TIME   = 2'd1,
        CFG_DCLICK_TIME = 2'd2
    } t_cfg_addr;

    typedef struct packed {
        logic [MASK_W-1:0] event_mask;
        logic [TIME_W-1:0] hold_time;
        logic [TIME_W-1:0] dclick_time;
    } t_cfg;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              pressed;
        logic [MODE_W-1:0] enable_mode;
        logic [SECS_W-1:0] disable_seconds;
    } t_in_item;

    typedef struct packed {
        t_event            event_code;
        logic              last;
        t_state            button_state;
        logic [MASK_W-1:0] active_mask;
        t_led              led_cmd;
    } t_res;

    typedef struct packed {
        logic [1:0] count;
        t_res       res0;
        t_res       res1;
    } t_res_pair;

    typedef struct packed {
        logic room_one;
        logic room_two;
    } t_q_status;

    function automatic logic [2:0] low_bit(input logic [NUM_EV-1:0] v);
        logic [2:0] idx;
        idx = '0;
        for (int i = NUM_EV - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    function automatic t_event bit_event(input logic [2:0] idx);
        return t_event'(EVT_W'(idx + 3'd1));
    endfunction

endpackage

@@ rtl/core/bchd_if.sv @@
// Handshake channels of the detector: input requests, results, register writes.
// Depends on bchd_pkg for field widths.
interface bchd_in_if;
    import bchd_pkg::*;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic              pressed;
    logic [MODE_W-1:0] enable_mode;
    logic [SECS_W-1:0] disable_seconds;
    modport source(output valid, func, pressed, enable_mode, disable_seconds, input ready);
    modport sink(input valid, func, pressed, enable_mode, disable_seconds, output ready);
endinterface

interface bchd_out_if;
    import bchd_pkg::*;
    logic               valid;
    logic               ready;
    logic [EVT_W-1:0]   event_code;
    logic               last;
    logic [STATE_W-1:0] button_state;
    logic [MASK_W-1:0]  active_mask;
    logic [LED_W-1:0]   led_cmd;
    modport source(output valid, event_code, last, button_state, active_mask, led_cmd,
                   input ready);
    modport sink(input valid, event_code, last, button_state, active_mask, led_cmd,
                 output ready);
endinterface

interface bchd_cfg_if;
    import bchd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, addr, data, input ready);
    modport sink(input valid, addr, data, output ready);
endinterface

@@ rtl/core/button_click_hold_detector.sv @@
// Button click, double-click and hold detector: top level.
// Flow: an accepted request waits in the input register until it fires, is then
// committed to the core state, and its results enter the registered output buffer.
// Throughput: one request per cycle while the buffer has room for its results.
// Reset: synchronous, active low; button released, mask 127, all counters zero.
// Depends on bchd_pkg, bchd_if, bchd_cfg, bchd_core and bchd_outq.
module button_click_hold_detector (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bchd_in_if.sink    i_in,
    bchd_cfg_if.sink   i_cfg,
    bchd_out_if.source o_out
);
    import bchd_pkg::*;

    logic      r_in_valid;
    t_in_item  r_item;
    logic      w_fire;
    t_cfg      w_cfg;
    logic      w_mask_load;
    t_res_pair w_res;
    t_res_pair w_push;
    t_q_status w_q;

    assign w_fire = r_in_valid &&
                    ((w_res.count == 2'd0) ||
                     ((w_res.count == 2'd1) && w_q.room_one) ||
                     w_q.room_two);

    assign i_in.ready = i_rst_n && (!r_in_valid || w_fire);

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.func            <= i_in.func;
            r_item.pressed         <= i_in.pressed;
            r_item.enable_mode     <= i_in.enable_mode;
            r_item.disable_seconds <= i_in.disable_seconds;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    bchd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .o_cfg       (w_cfg),
        .o_mask_load (w_mask_load)
    );

    bchd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (r_item),
        .i_fire      (w_fire),
        .i_cfg       (w_cfg),
        .i_mask_load (w_mask_load),
        .o_res       (w_res)
    );

    always_comb begin
        w_push = w_res;
        if (!w_fire) begin
            w_push.count = 2'd0;
        end
    end

    bchd_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .o_status (w_q),
        .o_out    (o_out)
    );

endmodule

@@ rtl/core/bchd_cfg.sv @@
// Configuration registers: event mask, hold time, double-click time.
// Depends on bchd_pkg and bchd_cfg_if.
module bchd_cfg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bchd_cfg_if.sink          i_cfg,
    output bchd_pkg::t_cfg    o_cfg,
    output logic              o_mask_load
);
    import bchd_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic r_mask_load;
    logic n_mask_load;
    logic w_wr;

    assign i_cfg.ready = i_rst_n;
    assign w_wr        = i_cfg.valid && i_cfg.ready;

    always_comb begin
        n_cfg       = r_cfg;
        n_mask_load = 1'b0;
        if (w_wr) begin
            case (t_cfg_addr'(i_cfg.addr))
                CFG_EVENT_MASK: begin
                    n_cfg.event_mask = i_cfg.data[MASK_W-1:0];
                    n_mask_load      = 1'b1;
                end
                CFG_HOLD_TIME:   n_cfg.hold_time   = i_cfg.data[TIME_W-1:0];
                CFG_DCLICK_TIME: n_cfg.dclick_time = i_cfg.data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.event_mask  <= RST_EVENT_MASK;
            r_cfg.hold_time   <= RST_HOLD_TIME;
            r_cfg.dclick_time <= RST_DCLICK_TIME;
            r_mask_load       <= 1'b0;
        end else begin
            r_cfg       <= n_cfg;
            r_mask_load <= n_mask_load;
        end
    end

    assign o_cfg       = r_cfg;
    assign o_mask_load = r_mask_load;

endmodule

@@ rtl/core/bchd_core.sv @@
// Button state machine, timeout and disable countdown; forms up to two results.
// Depends on bchd_pkg.
module bchd_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bchd_pkg::t_in_item   i_item,
    input  logic                 i_fire,
    input  bchd_pkg::t_cfg       i_cfg,
    input  logic                 i_mask_load,
    output bchd_pkg::t_res_pair  o_res
);
    import bchd_pkg::*;

    t_state                r_state,    n_state;
    logic [MASK_W-1:0]     r_mask,     n_mask;
    logic [TIME_W-1:0]     r_timeout,  n_timeout;
    logic [PRESCALE_W-1:0] r_prescale, n_prescale;
    logic [SECS_W-1:0]     r_disabled, n_disabled;

    logic [NUM_EV-1:0] w_ev;
    logic [NUM_EV-1:0] w_evm;
    logic [NUM_EV-1:0] w_evm_rest;
    t_led              w_led;
    logic              w_status;
    logic              w_enable;
    logic              w_has0;
    logic              w_has1;

    always_comb begin
        n_state    = r_state;
        n_mask     = r_mask;
        n_timeout  = r_timeout;
        n_prescale = r_prescale;
        n_disabled = r_disabled;
        w_ev       = '0;
        w_led      = LED_NONE;
        w_status   = 1'b0;
        w_enable   = 1'b0;
        case (t_func'(i_item.func))
            FUNC_LEVEL: begin
                if (r_mask != '0) begin
                    if (i_item.pressed) begin
                        w_ev[EVB_COVERED] = 1'b1;
                        if (r_mask[EVB_FEEDBACK]) begin
                            w_led = LED_ON;
                        end
                        case (r_state)
                            ST_RELEASED: begin
                                n_state = ST_PRESSED;
                                if (r_mask[EVB_HOLD_START]) begin
                                    n_timeout = i_cfg.hold_time;
                                end
                            end
                            ST_CLICKED: begin
                                n_state   = ST_CLICKED_PRESSED;
                                n_timeout = i_cfg.hold_time;
                            end
                            default: ;
                        endcase
                    end else begin
                        w_ev[EVB_FREE] = 1'b1;
                        if (r_mask[EVB_FEEDBACK]) begin
                            w_led = LED_OFF;
                        end
                        case (r_state)
                            ST_PRESSED: begin
                                if (r_mask[EVB_DOUBLE]) begin
                                    n_state   = ST_CLICKED;
                                    n_timeout = i_cfg.dclick_time;
                                end else begin
                                    n_state           = ST_RELEASED;
                                    w_ev[EVB_CLICKED] = 1'b1;
                                    n_timeout         = '0;
                                end
                            end
                            ST_HOLD: begin
                                n_state            = ST_RELEASED;
                                w_ev[EVB_HOLD_END] = 1'b1;
                            end
                            ST_CLICKED_PRESSED: begin
                                n_state          = ST_RELEASED;
                                w_ev[EVB_DOUBLE] = 1'b1;
                                n_timeout        = '0;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            FUNC_TICK: begin
                if (r_disabled != '0) begin
                    if (r_prescale >= PRESCALE_LAST) begin
                        n_prescale = '0;
                        n_disabled = SECS_W'(r_disabled - 1'b1);
                        if (r_disabled == SECS_W'(1)) begin
                            n_mask = i_cfg.event_mask;
                        end
                    end else begin
                        n_prescale = PRESCALE_W'(r_prescale + 1'b1);
                    end
                end else if (r_timeout != '0) begin
                    n_timeout = TIME_W'(r_timeout - 1'b1);
                    if (r_timeout == TIME_W'(1)) begin
                        case (r_state)
                            ST_PRESSED: begin
                                n_state              = ST_HOLD;
                                w_ev[EVB_HOLD_START] = 1'b1;
                            end
                            ST_CLICKED: begin
                                n_state           = ST_RELEASED;
                                w_ev[EVB_CLICKED] = 1'b1;
                            end
                            ST_CLICKED_PRESSED: begin
                                n_state              = ST_HOLD;
                                w_ev[EVB_CLICKED]    = 1'b1;
                                w_ev[EVB_HOLD_START] = 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            FUNC_ENABLE: begin
                w_enable   = (t_mode'(i_item.enable_mode) == MODE_ENABLE) ||
                             ((t_mode'(i_item.enable_mode) == MODE_INVERT) && (r_mask == '0));
                n_disabled = w_enable ? '0 : i_item.disable_seconds;
                n_prescale = '0;
                n_mask     = w_enable ? i_cfg.event_mask : '0;
            end
            FUNC_STATUS: w_status = 1'b1;
            default: ;
        endcase
    end

    assign w_evm      = w_ev & r_mask[NUM_EV-1:0];
    assign w_evm_rest = w_evm & NUM_EV'(w_evm - 1'b1);
    assign w_has0     = |w_evm;
    assign w_has1     = |w_evm_rest;

    always_comb begin
        o_res.res0.event_code   = w_has0 ? bit_event(low_bit(w_evm)) : EV_NONE;
        o_res.res0.last         = !w_has1;
        o_res.res0.button_state = n_state;
        o_res.res0.active_mask  = n_mask;
        o_res.res0.led_cmd      = w_led;
        o_res.res1.event_code   = bit_event(low_bit(w_evm_rest));
        o_res.res1.last         = 1'b1;
        o_res.res1.button_state = n_state;
        o_res.res1.active_mask  = n_mask;
        o_res.res1.led_cmd      = LED_NONE;
        if (w_status) begin
            o_res.count = 2'd1;
        end else if (w_has1) begin
            o_res.count = 2'd2;
        end else if (w_has0 || (w_led != LED_NONE)) begin
            o_res.count = 2'd1;
        end else begin
            o_res.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_RELEASED;
            r_mask     <= RST_EVENT_MASK;
            r_timeout  <= '0;
            r_prescale <= '0;
            r_disabled <= '0;
        end else begin
            if (i_fire) begin
                r_state    <= n_state;
                r_mask     <= n_mask;
                r_timeout  <= n_timeout;
                r_prescale <= n_prescale;
                r_disabled <= n_disabled;
            end
            if (i_mask_load) begin
                r_mask <= i_cfg.event_mask;
            end
        end
    end

endmodule

@@ rtl/core/bchd_outq.sv @@
// Two-entry result buffer that drains one result per cycle, while the output is ready.
// Depends on bchd_pkg and bchd_out_if.
module bchd_outq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bchd_pkg::t_res_pair  i_push,
    output bchd_pkg::t_q_status  o_status,
    bchd_out_if.source           o_out
);
    import bchd_pkg::*;

    t_res       r_slot [2];
    t_res       n_slot [2];
    logic [1:0] r_count;
    logic [1:0] n_count;
    logic       w_pop;
    logic [1:0] w_rem;

    assign w_pop = (r_count != 2'd0) && o_out.ready;
    assign w_rem = r_count - {1'b0, w_pop};

    assign o_status.room_one = (w_rem != 2'd2);
    assign o_status.room_two = (w_rem == 2'd0);

    always_comb begin
        n_slot = r_slot;
        if (w_pop) begin
            n_slot[0] = r_slot[1];
        end
        if (i_push.count != 2'd0) begin
            n_slot[w_rem[0]] = i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            n_slot[1] = i_push.res1;
        end
        n_count = w_rem + i_push.count;
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_out.valid        = (r_count != 2'd0);
    assign o_out.event_code   = r_slot[0].event_code;
    assign o_out.last         = r_slot[0].last;
    assign o_out.button_state = r_slot[0].button_state;
    assign o_out.active_mask  = r_slot[0].active_mask;
    assign o_out.led_cmd      = r_slot[0].led_cmd;

endmodule
